// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
// The condition must never hold.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- hw/rtl/iiee_pkg.sv -----
package iiee_pkg;

  // Operator codes as held on the operator stack.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIV_ZERO  = 3'd1,
    ST_MOD_ZERO  = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH,
    S_PUSH,
    S_REDUCE,
    S_WAIT,
    S_DRAIN,
    S_CHECK,
    S_OUT
  } state_e;

  // ASCII characters that the parser recognizes.
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Request to and response from the serial arithmetic unit.
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  // True for the higher precedence level.
  function automatic logic prec_hi(op_e op);
    return (op == OP_MUL) || (op == OP_DIV) || (op == OP_MOD);
  endfunction

endpackage

// ----- hw/rtl/iiee_alu.sv -----
// Bit-serial multiply, divide and remainder unit, one bit per cycle.
module iiee_alu #(
  parameter int unsigned W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iiee_pkg::alu_req_t req_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output iiee_pkg::alu_rsp_t rsp_o,
  output logic [W-1:0]       result_o
);
  import iiee_pkg::*;

  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] LastCnt = CW'(W - 1);

  logic          busy_q, busy_d, done_q, done_d;
  op_e           op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  x_q, x_d, y_q, y_d;
  logic [W-1:0]  z_q, z_d;
  logic          qneg_q, qneg_d, rneg_q, rneg_d;

  logic          na, nb;
  logic [W-1:0]  ma, mb;
  logic [W:0]    shifted, diff;
  logic          ge;

  // Operand magnitudes for the division.
  assign na = a_i[W-1];
  assign nb = b_i[W-1];
  assign ma = na ? (W'(0) - a_i) : a_i;
  assign mb = nb ? (W'(0) - b_i) : b_i;

  // One restoring division step.
  assign shifted = {z_q, x_q[W-1]};
  assign diff    = shifted - {1'b0, y_q};
  assign ge      = ~diff[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      z_d    = '0;
      qneg_d = na ^ nb;
      rneg_d = na;
      if (req_i.op == OP_MUL) begin
        x_d = a_i;
        y_d = b_i;
      end else begin
        x_d = ma;
        y_d = mb;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (op_q == OP_MUL) begin
        // Shift-and-add: the multiplier moves right, the multiplicand left.
        z_d = z_q + (x_q[0] ? y_q : '0);
        x_d = x_q >> 1;
        y_d = y_q << 1;
      end else begin
        z_d = ge ? diff[W-1:0] : shifted[W-1:0];
        x_d = {x_q[W-2:0], ge};
      end
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_NONE;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  // Result selection: the product as it is, or the sign-corrected final quotient or remainder.
  always_comb begin
    case (op_q)
      OP_MUL:  result_o = z_q;
      OP_DIV:  result_o = qneg_q ? (W'(0) - x_q) : x_q;
      default: result_o = rneg_q ? (W'(0) - z_q) : z_q;
    endcase
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

// ----- hw/rtl/infix_integer_expression_evaluator.sv -----
// Evaluates an infix integer expression fed one ASCII character per item, with
// +, -, *, / and % on two precedence levels, over VALUE_WIDTH-bit two's complement
// values; the item marked is_last yields one result (value sign-extended to 64 bits,
// and a status code). Digits, '.', a leading '-' and ignored characters are taken
// in S_IDLE. An operator stalls the input through S_FLUSH, S_PUSH and the
// reductions it triggers; + and - reduce in S_REDUCE itself, while *, / and % run
// in a bit-serial unit that S_WAIT waits for. Only one of those reductions can
// use the serial unit. The final item adds the reductions still pending, S_DRAIN
// and S_CHECK, and loads the result register in S_OUT once the previous result
// has been taken; the register lets the next expression start while the result
// waits.
`include "assert_macros.svh"

module infix_integer_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic [2:0]  status_o
);
  import iiee_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned TW = W + 4;
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  state_e       state_q, state_d, ret_q, ret_d;
  logic [W-1:0] v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic [1:0]   vc_q, vc_d, opc_q, opc_d;
  op_e          op0_q, op0_d, op1_q, op1_d;
  op_e          cur_q, cur_d, pend_q, pend_d;
  logic [W-1:0] acc_q, acc_d;
  logic         fs_q, fs_d, fn_q, fn_d, ff_q, ff_d, fd_q, fd_d;
  status_e      err_q, err_d;
  logic         end_q, end_d, last_q, last_d;
  logic         out_valid_q, out_valid_d;
  logic [63:0]  value_q, value_d;
  status_e      status_q, status_d;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] alu_res;

  logic         accept, load;
  op_e          top_op, ch_op;
  logic [W-1:0] va, vb, tv, nv, limit;
  logic [3:0]   dig;
  logic [TW-1:0] t;
  logic         is_digit, over;
  state_e       fin;

  iiee_alu #(.W(W)) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (va),
    .b_i     (vb),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = !out_valid_q || !out_stall_i;

  // Stack tops and operands.
  assign top_op = (opc_q == 2'd2) ? op1_q : op0_q;
  assign va     = (vc_q == 2'd3) ? v1_q : v0_q;
  assign vb     = (vc_q == 2'd3) ? v2_q : v1_q;
  assign tv     = (vc_q == 2'd3) ? v2_q : ((vc_q == 2'd2) ? v1_q : v0_q);

  // Decimal accumulation with overflow against the signed range.
  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig      = 4'(ch_i - CH_ZERO);
  assign t        = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + TW'(dig);
  assign limit    = fn_q ? SignBit : (SignBit - 1'b1);
  assign over     = t > {4'b0000, limit};
  assign nv       = fn_q ? (W'(0) - acc_q) : acc_q;

  // Operator code of the current character.
  always_comb begin
    case (ch_i)
      CH_PLUS:    ch_op = OP_ADD;
      CH_MINUS:   ch_op = OP_SUB;
      CH_STAR:    ch_op = OP_MUL;
      CH_SLASH:   ch_op = OP_DIV;
      CH_PERCENT: ch_op = OP_MOD;
      default:    ch_op = OP_NONE;
    endcase
  end

  // Where to go once an error has been recorded.
  assign fin = last_q ? S_CHECK : S_IDLE;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    v0_d        = v0_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    vc_d        = vc_q;
    opc_d       = opc_q;
    op0_d       = op0_q;
    op1_d       = op1_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    fs_d        = fs_q;
    fn_d        = fn_q;
    ff_d        = ff_q;
    fd_d        = fd_q;
    err_d       = err_q;
    end_d       = end_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    alu_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = is_last_i;
          end_d   = is_last_i;
          pend_d  = OP_NONE;
          state_d = is_last_i ? S_FLUSH : S_IDLE;
          if (err_q != ST_OK) begin
            end_d   = 1'b0;
            state_d = is_last_i ? S_CHECK : S_IDLE;
          end else if (is_digit) begin
            fs_d = 1'b1;
            if (!ff_q) begin
              if (over) begin
                err_d   = ST_OVERFLOW;
                end_d   = 1'b0;
                state_d = is_last_i ? S_CHECK : S_IDLE;
              end else begin
                acc_d = t[W-1:0];
                fd_d  = 1'b1;
              end
            end
          end else if (ch_i == CH_DOT) begin
            fs_d = 1'b1;
            ff_d = 1'b1;
          end else if ((ch_i == CH_MINUS) && !fs_q) begin
            fs_d = 1'b1;
            fn_d = 1'b1;
          end else if (ch_op != OP_NONE) begin
            cur_d   = ch_op;
            end_d   = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!fs_q) begin
          state_d = end_q ? S_DRAIN : S_PUSH;
        end else begin
          acc_d = '0;
          fs_d  = 1'b0;
          fn_d  = 1'b0;
          ff_d  = 1'b0;
          fd_d  = 1'b0;
          if (!fd_q) begin
            // A lone minus becomes a subtraction.
            if (fn_q && !ff_q) begin
              cur_d   = OP_SUB;
              pend_d  = end_q ? OP_NONE : cur_q;
              state_d = S_PUSH;
            end else begin
              err_d   = ST_MALFORMED;
              state_d = fin;
            end
          end else if (vc_q == 2'd3) begin
            err_d   = ST_MALFORMED;
            state_d = fin;
          end else begin
            case (vc_q)
              2'd0:    v0_d = nv;
              2'd1:    v1_d = nv;
              default: v2_d = nv;
            endcase
            vc_d    = vc_q + 1'b1;
            state_d = end_q ? S_DRAIN : S_PUSH;
          end
        end
      end

      S_PUSH: begin
        if ((opc_q != 2'd0) && (prec_hi(top_op) || !prec_hi(cur_q))) begin
          ret_d   = S_PUSH;
          state_d = S_REDUCE;
        end else if (opc_q == 2'd2) begin
          err_d   = ST_MALFORMED;
          state_d = fin;
        end else begin
          if (opc_q == 2'd0) begin
            op0_d = cur_q;
          end else begin
            op1_d = cur_q;
          end
          opc_d = opc_q + 1'b1;
          if (pend_q != OP_NONE) begin
            cur_d  = pend_q;
            pend_d = OP_NONE;
          end else if (end_q) begin
            state_d = S_DRAIN;
          end else if (last_q) begin
            end_d   = 1'b1;
            state_d = S_FLUSH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_REDUCE: begin
        opc_d = opc_q - 1'b1;
        if (vc_q < 2'd2) begin
          err_d   = ST_MALFORMED;
          state_d = fin;
        end else begin
          state_d = ret_q;
          case (top_op) inside
            OP_ADD, OP_SUB: begin
              if (vc_q == 2'd3) begin
                v1_d = (top_op == OP_ADD) ? (va + vb) : (va - vb);
              end else begin
                v0_d = (top_op == OP_ADD) ? (va + vb) : (va - vb);
              end
              vc_d = vc_q - 1'b1;
            end
            OP_MUL: begin
              alu_req.start = 1'b1;
              alu_req.op    = OP_MUL;
              state_d       = S_WAIT;
            end
            OP_DIV, OP_MOD: begin
              if (vb == '0) begin
                err_d   = (top_op == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
                state_d = fin;
              end else begin
                alu_req.start = 1'b1;
                alu_req.op    = top_op;
                state_d       = S_WAIT;
              end
            end
            default: begin
              if (vc_q == 2'd3) begin
                v1_d = '0;
              end else begin
                v0_d = '0;
              end
              vc_d = vc_q - 1'b1;
            end
          endcase
        end
      end

      S_WAIT: begin
        if (alu_rsp.done) begin
          if (vc_q == 2'd3) begin
            v1_d = alu_res;
          end else begin
            v0_d = alu_res;
          end
          vc_d    = vc_q - 1'b1;
          state_d = ret_q;
        end
      end

      S_DRAIN: begin
        if ((err_q != ST_OK) || (opc_q == 2'd0)) begin
          state_d = S_CHECK;
        end else begin
          ret_d   = S_DRAIN;
          state_d = S_REDUCE;
        end
      end

      S_CHECK: begin
        if ((err_q == ST_OK) && (vc_q == 2'd0)) begin
          err_d = ST_MALFORMED;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        // Hand the result over and start the next expression from scratch.
        if (load) begin
          out_valid_d = 1'b1;
          value_d     = (err_q == ST_OK) ? 64'($signed(tv)) : 64'd0;
          status_d    = err_q;
          vc_d        = 2'd0;
          opc_d       = 2'd0;
          op0_d       = OP_NONE;
          op1_d       = OP_NONE;
          acc_d       = '0;
          fs_d        = 1'b0;
          fn_d        = 1'b0;
          ff_d        = 1'b0;
          fd_d        = 1'b0;
          err_d       = ST_OK;
          end_d       = 1'b0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_PUSH;
      vc_q        <= 2'd0;
      opc_q       <= 2'd0;
      op0_q       <= OP_NONE;
      op1_q       <= OP_NONE;
      cur_q       <= OP_NONE;
      pend_q      <= OP_NONE;
      acc_q       <= '0;
      fs_q        <= 1'b0;
      fn_q        <= 1'b0;
      ff_q        <= 1'b0;
      fd_q        <= 1'b0;
      err_q       <= ST_OK;
      end_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      vc_q        <= vc_d;
      opc_q       <= opc_d;
      op0_q       <= op0_d;
      op1_q       <= op1_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      fs_q        <= fs_d;
      fn_q        <= fn_d;
      ff_q        <= ff_d;
      fd_q        <= fd_d;
      err_q       <= err_d;
      end_q       <= end_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Value stack and result payload.
  always_ff @(posedge clk_i) begin
    v0_q     <= v0_d;
    v1_q     <= v1_d;
    v2_q     <= v2_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  `ASSERT_NEVER(a_opc_range, clk_i, rst_ni, opc_q == 2'd3)
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), value_o == 64'd0)
  `ASSERT_IMPLIES(a_alu_free, clk_i, rst_ni, alu_req.start, !alu_rsp.busy)
  `ASSERT_IMPLIES(a_wait_alu, clk_i, rst_ni, state_q == S_WAIT, alu_rsp.busy || alu_rsp.done)

endmodule
